[rtl/wams_pkg.sv]
// Shared types, codes and default sizes of the weekday alarm melody sequencer.
// Used by the top level, wams_ctrl and wams_datapath; depends on nothing.
package wams_pkg;

   localparam int DEFAULT_NUM_ALARMS = 3;
   localparam int DEFAULT_MAX_NOTES  = 32;
   localparam int MS_PER_SECOND      = 1000;

   localparam int SETTING_WIDTH   = 34;
   localparam int SETTING_REGS    = 3;
   localparam int NOTE_WORD_WIDTH = 32;

   typedef logic [SETTING_WIDTH-1:0] setting_type;

   typedef enum logic [1:0] {
      FUNC_TICK       = 2'd0,
      FUNC_STOP_ALL   = 2'd1,
      FUNC_SET_ENABLE = 2'd2,
      FUNC_LOAD_NOTE  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      CSR_ALARM_ZERO = 2'd0,
      CSR_ALARM_ONE  = 2'd1,
      CSR_ALARM_TWO  = 2'd2,
      CSR_NOTE_COUNT = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_EVAL,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load_item;
      logic exec_op;
      logic read_alarm;
      logic eval_alarm;
      logic next_alarm;
      logic emit;
   } command_type;

   typedef struct packed {
      logic req_tick;
      logic last_alarm;
   } status_type;

endpackage

[rtl/weekday_alarm_melody_sequencer.sv]
// Top level of the weekday alarm melody sequencer: register file and glue.
// Depends on wams_pkg, wams_ctrl, wams_datapath (which holds wams_ram).
//
//   Channel   Signals                               Direction   Beat
//   req_      req_valid/req_ready + item fields     in          one item
//   rsp_      rsp_valid/rsp_ready + result fields   out         one result
//   csr_      psel/penable/pwrite/paddr/pwdata      in/out      one register write or read
//
// A tick beat passes through a read state and an evaluate state for each alarm, then the
// emit state: each alarm addresses the note table in its read state, whose read is
// registered, and evaluates its duration and melody step in the next, building on the last.
// Other items pass through the execute state and then the emit state. The next request beat
// is taken in the cycle after a result is registered, so no item is taken while one is in
// flight. Reset clears control and alarm state but not the note table; a result that is not
// taken holds the block in its emit state.
module weekday_alarm_melody_sequencer #(
   parameter int NUM_ALARMS = wams_pkg::DEFAULT_NUM_ALARMS,
   parameter int MAX_NOTES  = wams_pkg::DEFAULT_MAX_NOTES
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [4:0]  req_hour,
   input  logic [5:0]  req_minute,
   input  logic [2:0]  req_weekday,
   input  logic [31:0] req_now_ms,
   input  logic [1:0]  req_alarm_index,
   input  logic        req_enable,
   input  logic [4:0]  req_note_index,
   input  logic [15:0] req_note_freq,
   input  logic [15:0] req_note_ms,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_buzzer_freq,
   output logic        rsp_buzzer_on,
   output logic [2:0]  rsp_sounding_mask,
   output logic [2:0]  rsp_started_mask,
   output logic [2:0]  rsp_ended_mask,

   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

   // Registers sit eight bytes apart, so the index is taken from address bits 4:3.
   wams_pkg::setting_type [wams_pkg::SETTING_REGS-1:0] setting_ff, setting_in;
   logic [5:0] note_count_ff, note_count_in;
   wams_pkg::csr_index_type csr_index;
   logic csr_write;

   wams_pkg::command_type cmd;
   wams_pkg::status_type  status;

   assign csr_pready = 1'b1;
   assign csr_index  = wams_pkg::csr_index_type'(csr_paddr[4:3]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      setting_in    = setting_ff;
      note_count_in = note_count_ff;
      if (csr_write) begin
         case (csr_index)
            wams_pkg::CSR_ALARM_ZERO: setting_in[0] = csr_pwdata[33:0];
            wams_pkg::CSR_ALARM_ONE:  setting_in[1] = csr_pwdata[33:0];
            wams_pkg::CSR_ALARM_TWO:  setting_in[2] = csr_pwdata[33:0];
            wams_pkg::CSR_NOTE_COUNT: note_count_in = csr_pwdata[5:0];
            default: begin
               note_count_in = note_count_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         wams_pkg::CSR_ALARM_ZERO: csr_prdata = 64'(setting_ff[0]);
         wams_pkg::CSR_ALARM_ONE:  csr_prdata = 64'(setting_ff[1]);
         wams_pkg::CSR_ALARM_TWO:  csr_prdata = 64'(setting_ff[2]);
         wams_pkg::CSR_NOTE_COUNT: csr_prdata = 64'(note_count_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   // The note count comes out of reset as one, so the melody repeats its first note.
   always_ff @(posedge clock) begin
      if (reset) begin
         setting_ff    <= '0;
         note_count_ff <= 6'd1;
      end else begin
         setting_ff    <= setting_in;
         note_count_ff <= note_count_in;
      end
   end

   wams_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .status   (status),
      .cmd      (cmd)
   );

   wams_datapath #(
      .NUM_ALARMS(NUM_ALARMS),
      .MAX_NOTES (MAX_NOTES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .alarm_setting    (setting_ff),
      .note_count       (note_count_ff),
      .req_func         (req_func),
      .req_hour         (req_hour),
      .req_minute       (req_minute),
      .req_weekday      (req_weekday),
      .req_now_ms       (req_now_ms),
      .req_alarm_index  (req_alarm_index),
      .req_enable       (req_enable),
      .req_note_index   (req_note_index),
      .req_note_freq    (req_note_freq),
      .req_note_ms      (req_note_ms),
      .rsp_buzzer_freq  (rsp_buzzer_freq),
      .rsp_buzzer_on    (rsp_buzzer_on),
      .rsp_sounding_mask(rsp_sounding_mask),
      .rsp_started_mask (rsp_started_mask),
      .rsp_ended_mask   (rsp_ended_mask)
   );

endmodule

[rtl/wams_ram.sv]
// Generic single write port, single read port RAM with a registered read.
// Stands alone; holds the melody note table.
module wams_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/wams_ctrl.sv]
// Sequencing state machine of the weekday alarm melody sequencer.
// Depends on wams_pkg; drives the datapath through command and status structs.
module wams_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  wams_pkg::status_type status,
   output wams_pkg::command_type cmd
);

   wams_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         wams_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = status.req_tick ? wams_pkg::ST_READ : wams_pkg::ST_EXEC;
            end
         end
         wams_pkg::ST_EXEC: begin
            state_in = wams_pkg::ST_EMIT;
         end
         wams_pkg::ST_READ: begin
            state_in = wams_pkg::ST_EVAL;
         end
         wams_pkg::ST_EVAL: begin
            state_in = status.last_alarm ? wams_pkg::ST_EMIT : wams_pkg::ST_READ;
         end
         wams_pkg::ST_EMIT: begin
            if (out_free) begin
               state_in = wams_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wams_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd            = '0;
      req_ready      = 1'b0;
      cmd.load_item  = 1'b0;
      case (state_ff)
         wams_pkg::ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_item = req_valid;
         end
         wams_pkg::ST_EXEC: begin
            cmd.exec_op = 1'b1;
         end
         wams_pkg::ST_READ: begin
            cmd.read_alarm = 1'b1;
         end
         wams_pkg::ST_EVAL: begin
            cmd.eval_alarm = 1'b1;
            cmd.next_alarm = !status.last_alarm;
         end
         wams_pkg::ST_EMIT: begin
            cmd.emit = out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wams_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/wams_datapath.sv]
// Alarm state, melody stepper, note table and result register of the sequencer.
// Depends on wams_pkg and wams_ram; steered by wams_ctrl.
module wams_datapath #(
   parameter int NUM_ALARMS = wams_pkg::DEFAULT_NUM_ALARMS,
   parameter int MAX_NOTES  = wams_pkg::DEFAULT_MAX_NOTES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  wams_pkg::command_type cmd,
   output wams_pkg::status_type  status,
   input  wams_pkg::setting_type [wams_pkg::SETTING_REGS-1:0] alarm_setting,
   input  logic [5:0]            note_count,
   input  logic [1:0]            req_func,
   input  logic [4:0]            req_hour,
   input  logic [5:0]            req_minute,
   input  logic [2:0]            req_weekday,
   input  logic [31:0]           req_now_ms,
   input  logic [1:0]            req_alarm_index,
   input  logic                  req_enable,
   input  logic [4:0]            req_note_index,
   input  logic [15:0]           req_note_freq,
   input  logic [15:0]           req_note_ms,
   output logic [15:0]           rsp_buzzer_freq,
   output logic                  rsp_buzzer_on,
   output logic [2:0]            rsp_sounding_mask,
   output logic [2:0]            rsp_started_mask,
   output logic [2:0]            rsp_ended_mask
);

   localparam int IW = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;
   localparam int AW = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;

   // Latched item
   wams_pkg::func_type func_ff;
   logic [4:0]  hour_ff;
   logic [5:0]  minute_ff;
   logic [2:0]  weekday_ff;
   logic [31:0] now_ff;
   logic [1:0]  alarm_index_ff;
   logic        enable_ff;
   logic [4:0]  note_index_ff;
   logic [15:0] note_freq_ff;
   logic [15:0] note_ms_ff;

   // Alarm and melody state
   logic [NUM_ALARMS-1:0] enabled_ff, enabled_in;
   logic [NUM_ALARMS-1:0] fired_ff, fired_in;
   logic [NUM_ALARMS-1:0] sounding_ff, sounding_in;
   logic [NUM_ALARMS-1:0][31:0] start_ms_ff, start_ms_in;
   logic [NUM_ALARMS-1:0] started_ff, started_in;
   logic [NUM_ALARMS-1:0] ended_ff, ended_in;
   logic [AW-1:0]  pos_ff, pos_in;
   logic [31:0]    last_change_ff, last_change_in;
   logic [15:0]    tone_freq_ff, tone_freq_in;
   logic           tone_active_ff, tone_active_in;
   logic [IW-1:0]  alarm_cnt_ff, alarm_cnt_in;
   logic [31:0]    elapsed_ff, elapsed_in;
   logic [25:0]    limit_ff, limit_in;

   // Result register
   logic [15:0] rsp_freq_ff;
   logic        rsp_on_ff;
   logic [2:0]  rsp_sounding_ff, rsp_started_ff, rsp_ended_ff;

   wams_pkg::setting_type cur_setting;
   logic [31:0] cur_start;
   logic [7:0]  day_bits;
   logic        start_now;
   logic [8:0]  notes_n;
   logic [8:0]  pos_plus;
   logic [8:0]  note_idx_ext;
   logic        ram_we;
   logic [wams_pkg::NOTE_WORD_WIDTH-1:0] ram_rdata;
   logic [15:0] rd_freq, rd_len;

   assign status.req_tick   = (wams_pkg::func_type'(req_func) == wams_pkg::FUNC_TICK);
   assign status.last_alarm = (alarm_cnt_ff == IW'(NUM_ALARMS - 1));

   assign note_idx_ext = 9'(note_index_ff);
   assign ram_we = cmd.exec_op && (func_ff == wams_pkg::FUNC_LOAD_NOTE)
                   && (note_idx_ext < 9'(MAX_NOTES));

   wams_ram #(
      .WIDTH(wams_pkg::NOTE_WORD_WIDTH),
      .DEPTH(MAX_NOTES)
   ) u_note_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(note_idx_ext[AW-1:0]),
      .wr_data({note_freq_ff, note_ms_ff}),
      .rd_addr(pos_ff),
      .rd_data(ram_rdata)
   );

   assign rd_freq = ram_rdata[31:16];
   assign rd_len  = ram_rdata[15:0];

   always_comb begin
      cur_setting = '0;
      cur_start   = '0;
      for (int i = 0; i < NUM_ALARMS; i++) begin
         if (alarm_cnt_ff == IW'(i)) begin
            cur_setting = alarm_setting[i];
            cur_start   = start_ms_ff[i];
         end
      end
   end

   // A weekday of seven finds the padding bit and so matches nothing.
   assign day_bits  = {1'b0, cur_setting[17:11]};
   assign start_now = enabled_ff[alarm_cnt_ff] && day_bits[weekday_ff]
                      && !fired_ff[alarm_cnt_ff]
                      && (hour_ff == cur_setting[4:0]) && (minute_ff == cur_setting[10:5]);

   always_comb begin
      notes_n = 9'(note_count);
      if (note_count == 6'd0) begin
         notes_n = 9'd1;
      end else if (notes_n > 9'(MAX_NOTES)) begin
         notes_n = 9'(MAX_NOTES);
      end
   end

   assign pos_plus = 9'(pos_ff) + 9'd1;

   always_comb begin
      enabled_in     = enabled_ff;
      fired_in       = fired_ff;
      sounding_in    = sounding_ff;
      start_ms_in    = start_ms_ff;
      started_in     = started_ff;
      ended_in       = ended_ff;
      pos_in         = pos_ff;
      last_change_in = last_change_ff;
      tone_freq_in   = tone_freq_ff;
      tone_active_in = tone_active_ff;
      alarm_cnt_in   = alarm_cnt_ff;
      elapsed_in     = elapsed_ff;
      limit_in       = limit_ff;

      if (cmd.load_item) begin
         started_in   = '0;
         ended_in     = '0;
         alarm_cnt_in = '0;
         if (status.req_tick && req_hour == 5'd0 && req_minute == 6'd0) begin
            fired_in = '0;
         end
      end

      if (cmd.exec_op) begin
         case (func_ff)
            wams_pkg::FUNC_STOP_ALL: begin
               sounding_in    = '0;
               tone_active_in = 1'b0;
               tone_freq_in   = '0;
               pos_in         = '0;
               last_change_in = '0;
            end
            wams_pkg::FUNC_SET_ENABLE: begin
               for (int i = 0; i < NUM_ALARMS; i++) begin
                  if (alarm_index_ff == 2'(i)) begin
                     if (enable_ff) begin
                        enabled_in[i] = 1'b1;
                     end else begin
                        enabled_in[i]  = 1'b0;
                        sounding_in[i] = 1'b0;
                        tone_active_in = 1'b0;
                        tone_freq_in   = '0;
                        pos_in         = '0;
                        last_change_in = '0;
                     end
                  end
               end
            end
            default: begin
               enabled_in = enabled_ff;
            end
         endcase
      end

      if (cmd.read_alarm) begin
         limit_in = 26'(cur_setting[33:18]) * 26'(wams_pkg::MS_PER_SECOND);
         if (start_now) begin
            sounding_in[alarm_cnt_ff] = 1'b1;
            fired_in[alarm_cnt_ff]    = 1'b1;
            started_in[alarm_cnt_ff]  = 1'b1;
            for (int i = 0; i < NUM_ALARMS; i++) begin
               if (alarm_cnt_ff == IW'(i)) begin
                  start_ms_in[i] = now_ff;
               end
            end
            elapsed_in = '0;
         end else begin
            elapsed_in = now_ff - cur_start;
         end
      end

      if (cmd.eval_alarm && sounding_ff[alarm_cnt_ff]) begin
         if (elapsed_ff <= 32'(limit_ff)) begin
            if ((now_ff - last_change_ff) >= 32'(rd_len)) begin
               tone_freq_in   = rd_freq;
               tone_active_in = (rd_freq != 16'd0);
               last_change_in = now_ff;
               pos_in         = (pos_plus >= notes_n) ? '0 : pos_plus[AW-1:0];
            end
         end else begin
            sounding_in[alarm_cnt_ff] = 1'b0;
            ended_in[alarm_cnt_ff]    = 1'b1;
            tone_active_in = 1'b0;
            tone_freq_in   = '0;
            pos_in         = '0;
            last_change_in = '0;
         end
      end

      if (cmd.next_alarm) begin
         alarm_cnt_in = alarm_cnt_ff + IW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff     <= '0;
         fired_ff       <= '0;
         sounding_ff    <= '0;
         start_ms_ff    <= '0;
         started_ff     <= '0;
         ended_ff       <= '0;
         pos_ff         <= '0;
         last_change_ff <= '0;
         tone_freq_ff   <= '0;
         tone_active_ff <= 1'b0;
         alarm_cnt_ff   <= '0;
      end else begin
         enabled_ff     <= enabled_in;
         fired_ff       <= fired_in;
         sounding_ff    <= sounding_in;
         start_ms_ff    <= start_ms_in;
         started_ff     <= started_in;
         ended_ff       <= ended_in;
         pos_ff         <= pos_in;
         last_change_ff <= last_change_in;
         tone_freq_ff   <= tone_freq_in;
         tone_active_ff <= tone_active_in;
         alarm_cnt_ff   <= alarm_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      elapsed_ff <= elapsed_in;
      limit_ff   <= limit_in;
      if (cmd.load_item) begin
         func_ff        <= wams_pkg::func_type'(req_func);
         hour_ff        <= req_hour;
         minute_ff      <= req_minute;
         weekday_ff     <= req_weekday;
         now_ff         <= req_now_ms;
         alarm_index_ff <= req_alarm_index;
         enable_ff      <= req_enable;
         note_index_ff  <= req_note_index;
         note_freq_ff   <= req_note_freq;
         note_ms_ff     <= req_note_ms;
      end
      if (cmd.emit) begin
         rsp_freq_ff     <= tone_active_ff ? tone_freq_ff : 16'd0;
         rsp_on_ff       <= tone_active_ff;
         rsp_sounding_ff <= 3'(sounding_ff);
         rsp_started_ff  <= 3'(started_ff);
         rsp_ended_ff    <= 3'(ended_ff);
      end
   end

   assign rsp_buzzer_freq   = rsp_freq_ff;
   assign rsp_buzzer_on     = rsp_on_ff;
   assign rsp_sounding_mask = rsp_sounding_ff;
   assign rsp_started_mask  = rsp_started_ff;
   assign rsp_ended_mask    = rsp_ended_ff;

endmodule
